>>> rtl/core/cdr_pkg.sv
package cdr_pkg;

  // Item field widths
  localparam int MODE_W     = 3;
  localparam int COL_IN_W   = 7;
  localparam int ROW_IN_W   = 2;
  localparam int CODE_W     = 7;
  localparam int KIND_W     = 2;
  localparam int PCOL_OUT_W = 6;

  // Defaults for the display geometry
  localparam int DEF_NUM_PANELS    = 2;
  localparam int DEF_PANEL_COLUMNS = 40;
  localparam int DEF_NUM_ROWS      = 2;

  // Refresh search looks at this many cells per cycle
  localparam int LANES  = 8;
  localparam int LANE_W = 3;

  localparam logic [CODE_W-1:0] SPACE_CODE = 7'h20;
  localparam logic [CODE_W-1:0] ZERO_CODE  = 7'h00;

  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_CURSOR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUT_CURSOR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PUT_POS    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REFRESH    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRANSFER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

  // Controller -> datapath
  typedef struct packed {
    logic              capture;
    logic              do_clear;
    logic              set_cursor;
    logic              rd_cell;
    logic              wr_cell;
    logic              scan_init;
    logic              scan_next;
    logic              scan_hit;
    logic              scan_done;
    logic              xfer;
    logic              res_load;
    logic [KIND_W-1:0] res_kind;
    logic              emit;
  } cdr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              range_ok;
    logic              scan_at_end;
    logic              hit;
    logic              last_chunk;
    logic              out_free;
  } cdr_stat_t;

endpackage

>>> rtl/core/cdr_ram.sv
module cdr_ram #(
  parameter int WIDTH = cdr_pkg::CODE_W,
  parameter int DEPTH = 2 * cdr_pkg::DEF_NUM_ROWS * cdr_pkg::DEF_PANEL_COLUMNS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/cdr_controller.sv
module cdr_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cdr_pkg::cdr_stat_t  stat,
  output cdr_pkg::cdr_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RMW  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_XFER = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.mode)
          cdr_pkg::MODE_CLEAR: begin
            cmd.do_clear = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_kind = cdr_pkg::KIND_ACCEPTED;
            state_nxt    = S_EMIT;
          end
          cdr_pkg::MODE_SET_CURSOR: begin
            cmd.set_cursor = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_kind   = cdr_pkg::KIND_ACCEPTED;
            state_nxt      = S_EMIT;
          end
          cdr_pkg::MODE_PUT_CURSOR, cdr_pkg::MODE_PUT_POS: begin
            if (stat.range_ok) begin
              cmd.rd_cell = 1'b1;
              state_nxt   = S_RMW;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_kind = cdr_pkg::KIND_REJECTED;
              state_nxt    = S_EMIT;
            end
          end
          cdr_pkg::MODE_REFRESH: begin
            if (stat.scan_at_end) begin
              cmd.scan_done = 1'b1;
              cmd.res_load  = 1'b1;
              cmd.res_kind  = cdr_pkg::KIND_DONE;
              state_nxt     = S_EMIT;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = cdr_pkg::KIND_REJECTED;
            state_nxt    = S_EMIT;
          end
        endcase
      end
      S_RMW: begin
        cmd.wr_cell  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_kind = cdr_pkg::KIND_ACCEPTED;
        state_nxt    = S_EMIT;
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          cmd.scan_hit = 1'b1;
          state_nxt    = S_XFER;
        end else if (stat.last_chunk) begin
          cmd.scan_done = 1'b1;
          cmd.res_load  = 1'b1;
          cmd.res_kind  = cdr_pkg::KIND_DONE;
          state_nxt     = S_EMIT;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_XFER: begin
        cmd.xfer  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_xfer_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_XFER |-> $past(state_r) == S_SCAN)
    else $error("transfer state not entered from search");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EXEC)
    else $error("accepted word not dispatched");

endmodule

>>> rtl/core/cdr_datapath.sv
module cdr_datapath #(
  parameter int NUM_PANELS    = cdr_pkg::DEF_NUM_PANELS,
  parameter int PANEL_COLUMNS = cdr_pkg::DEF_PANEL_COLUMNS,
  parameter int NUM_ROWS      = cdr_pkg::DEF_NUM_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cdr_pkg::cdr_cmd_t               cmd,
  output cdr_pkg::cdr_stat_t              stat,
  input  logic [cdr_pkg::MODE_W-1:0]      in_mode,
  input  logic [cdr_pkg::COL_IN_W-1:0]    in_column,
  input  logic [cdr_pkg::ROW_IN_W-1:0]    in_row,
  input  logic [cdr_pkg::CODE_W-1:0]      in_char_code,
  input  logic                            in_force_req,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [cdr_pkg::KIND_W-1:0]      out_kind,
  output logic                            out_panel,
  output logic [cdr_pkg::PCOL_OUT_W-1:0]  out_panel_column,
  output logic                            out_row,
  output logic [cdr_pkg::CODE_W-1:0]      out_char,
  output logic                            out_cursor_needed
);

  localparam int TOTAL_COLUMNS = NUM_PANELS * PANEL_COLUMNS;
  localparam int CELL_COUNT    = NUM_ROWS * TOTAL_COLUMNS;
  localparam int ADDR_W        = $clog2(CELL_COUNT);
  localparam int SP_W          = $clog2(CELL_COUNT + 1);
  localparam int NCHUNK        = (CELL_COUNT + cdr_pkg::LANES - 1) / cdr_pkg::LANES;
  localparam int CHUNK_W       = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int SIDX_W        = CHUNK_W + cdr_pkg::LANE_W;
  localparam int ROW_W         = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int COL_W         = $clog2(TOTAL_COLUMNS);
  localparam int PNL_W         = (NUM_PANELS > 1) ? $clog2(NUM_PANELS) : 1;
  localparam int PCOL_W        = $clog2(PANEL_COLUMNS);

  // captured word
  logic [cdr_pkg::MODE_W-1:0]   mode_r;
  logic [cdr_pkg::COL_IN_W-1:0] col_r;
  logic [cdr_pkg::ROW_IN_W-1:0] row_r;
  logic [cdr_pkg::CODE_W-1:0]   code_r;
  logic                         force_r;

  logic [cdr_pkg::COL_IN_W-1:0] cur_col_r;
  logic [cdr_pkg::ROW_IN_W-1:0] cur_row_r;
  logic [SP_W-1:0]              scan_pos_r;
  logic [SP_W-1:0]              cont_pos_r;
  logic                         cont_valid_r;
  logic [ADDR_W-1:0]            idx_r;
  logic [CHUNK_W-1:0]           chunk_r;
  logic                         first_r;
  logic [cdr_pkg::CODE_W-1:0]   fill_r;
  logic [CELL_COUNT-1:0]        valid_r;
  logic [CELL_COUNT-1:0]        sent_r;

  logic [cdr_pkg::KIND_W-1:0]     res_kind_r;
  logic                           res_panel_r;
  logic [cdr_pkg::PCOL_OUT_W-1:0] res_pcol_r;
  logic                           res_row_r;
  logic [cdr_pkg::CODE_W-1:0]     res_char_r;
  logic                           res_need_r;

  logic                           out_valid_r;
  logic [cdr_pkg::KIND_W-1:0]     out_kind_r;
  logic                           out_panel_r;
  logic [cdr_pkg::PCOL_OUT_W-1:0] out_pcol_r;
  logic                           out_row_r;
  logic [cdr_pkg::CODE_W-1:0]     out_char_r;
  logic                           out_need_r;

  logic [cdr_pkg::COL_IN_W-1:0] sel_col;
  logic [cdr_pkg::ROW_IN_W-1:0] sel_row;
  logic                         range_ok;
  logic [ADDR_W-1:0]            tgt_idx;

  logic [cdr_pkg::LANES-1:0]    qual;
  logic [cdr_pkg::LANE_W-1:0]   hit_lane;
  logic [SIDX_W-1:0]            hit_sidx;
  logic [ADDR_W-1:0]            hit_idx;

  logic                         ram_we;
  logic                         ram_re;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [cdr_pkg::CODE_W-1:0]   ram_q;
  logic [cdr_pkg::CODE_W-1:0]   stored_code;
  logic                         differ;

  logic [ROW_W-1:0]             xy_row;
  logic [COL_W-1:0]             xy_col;
  logic [PNL_W-1:0]             xy_panel;
  logic [PCOL_W-1:0]            xy_pcol;
  logic                         need;
  logic [SP_W-1:0]              idx_next;

  // target cell for the put modes
  always_comb begin
    if (mode_r == cdr_pkg::MODE_PUT_CURSOR) begin
      sel_col = cur_col_r;
      sel_row = cur_row_r;
    end else begin
      sel_col = col_r;
      sel_row = row_r;
    end
    range_ok = (int'(sel_row) < NUM_ROWS) && (int'(sel_col) < TOTAL_COLUMNS);
    tgt_idx  = ADDR_W'(int'(sel_row) * TOTAL_COLUMNS + int'(sel_col));
  end

  // one group of cells per cycle; lowest qualifying lane wins
  always_comb begin
    logic [SIDX_W-1:0] lane_idx;
    logic              in_cells;
    logic              past_start;
    qual     = '0;
    hit_lane = '0;
    for (int l = 0; l < cdr_pkg::LANES; l++) begin
      lane_idx   = {chunk_r, cdr_pkg::LANE_W'(l)};
      in_cells   = int'(lane_idx) < CELL_COUNT;
      past_start = !first_r || (cdr_pkg::LANE_W'(l) >= scan_pos_r[cdr_pkg::LANE_W-1:0]);
      qual[l]    = in_cells && past_start &&
                   (force_r || !sent_r[lane_idx[ADDR_W-1:0]]);
    end
    for (int l = cdr_pkg::LANES - 1; l >= 0; l--) begin
      if (qual[l]) begin
        hit_lane = cdr_pkg::LANE_W'(l);
      end
    end
  end

  assign hit_sidx = {chunk_r, hit_lane};
  assign hit_idx  = hit_sidx[ADDR_W-1:0];

  // cell codes; never-written cells read as the fill code
  assign ram_re      = cmd.rd_cell || cmd.scan_hit;
  assign ram_raddr   = cmd.rd_cell ? tgt_idx : hit_idx;
  assign stored_code = valid_r[idx_r] ? ram_q : fill_r;
  assign differ      = (stored_code != code_r);
  assign ram_we      = cmd.wr_cell && differ;

  cdr_ram #(
    .WIDTH (cdr_pkg::CODE_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (code_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // cell index -> row / column -> panel / panel column, by constant compares
  always_comb begin
    xy_row = '0;
    xy_col = COL_W'(idx_r);
    for (int k = 1; k < NUM_ROWS; k++) begin
      if (int'(idx_r) >= k * TOTAL_COLUMNS) begin
        xy_row = ROW_W'(k);
        xy_col = COL_W'(idx_r - ADDR_W'(k * TOTAL_COLUMNS));
      end
    end
    xy_panel = '0;
    xy_pcol  = PCOL_W'(xy_col);
    for (int k = 1; k < NUM_PANELS; k++) begin
      if (int'(xy_col) >= k * PANEL_COLUMNS) begin
        xy_panel = PNL_W'(k);
        xy_pcol  = PCOL_W'(xy_col - COL_W'(k * PANEL_COLUMNS));
      end
    end
  end

  assign idx_next = SP_W'(idx_r) + SP_W'(1);
  assign need     = !(cont_valid_r && (cont_pos_r == SP_W'(idx_r)));

  always_comb begin
    stat             = '0;
    stat.mode        = mode_r;
    stat.range_ok    = range_ok;
    stat.scan_at_end = int'(scan_pos_r) >= CELL_COUNT;
    stat.hit         = |qual;
    stat.last_chunk  = (chunk_r == CHUNK_W'(NCHUNK - 1));
    stat.out_free    = !out_valid_r || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      scan_pos_r   <= '0;
      cont_pos_r   <= '0;
      cont_valid_r <= 1'b0;
      chunk_r      <= '0;
      first_r      <= 1'b0;
      fill_r       <= cdr_pkg::ZERO_CODE;
      valid_r      <= '0;
      sent_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.do_clear) begin
        cur_col_r <= '0;
        cur_row_r <= '0;
        fill_r    <= cdr_pkg::SPACE_CODE;
        valid_r   <= '0;
        sent_r    <= '0;
      end
      if (cmd.set_cursor) begin
        cur_col_r <= col_r;
        cur_row_r <= row_r;
      end
      if (cmd.wr_cell) begin
        if (differ) begin
          valid_r[idx_r] <= 1'b1;
          sent_r[idx_r]  <= 1'b0;
        end
        if (mode_r == cdr_pkg::MODE_PUT_CURSOR) begin
          cur_col_r <= cur_col_r + 1'b1;
        end
      end
      if (cmd.scan_init) begin
        chunk_r <= CHUNK_W'(scan_pos_r >> cdr_pkg::LANE_W);
        first_r <= 1'b1;
      end
      if (cmd.scan_next) begin
        chunk_r <= chunk_r + 1'b1;
        first_r <= 1'b0;
      end
      if (cmd.scan_done) begin
        scan_pos_r   <= '0;
        cont_valid_r <= 1'b0;
      end
      if (cmd.xfer) begin
        sent_r[idx_r] <= 1'b1;
        scan_pos_r    <= idx_next;
        cont_pos_r    <= idx_next;
        cont_valid_r  <= (int'(xy_pcol) != PANEL_COLUMNS - 1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      col_r   <= in_column;
      row_r   <= in_row;
      code_r  <= in_char_code;
      force_r <= in_force_req;
    end
    if (cmd.rd_cell) begin
      idx_r <= tgt_idx;
    end
    if (cmd.scan_hit) begin
      idx_r <= hit_idx;
    end
    if (cmd.res_load) begin
      res_kind_r  <= cmd.res_kind;
      res_panel_r <= 1'b0;
      res_pcol_r  <= '0;
      res_row_r   <= 1'b0;
      res_char_r  <= '0;
      res_need_r  <= 1'b0;
    end
    if (cmd.xfer) begin
      res_kind_r  <= cdr_pkg::KIND_TRANSFER;
      res_panel_r <= xy_panel[0];
      res_pcol_r  <= cdr_pkg::PCOL_OUT_W'(xy_pcol);
      res_row_r   <= xy_row[0];
      res_char_r  <= stored_code;
      res_need_r  <= need;
    end
    if (cmd.emit) begin
      out_kind_r  <= res_kind_r;
      out_panel_r <= res_panel_r;
      out_pcol_r  <= res_pcol_r;
      out_row_r   <= res_row_r;
      out_char_r  <= res_char_r;
      out_need_r  <= res_need_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_panel         = out_panel_r;
  assign out_panel_column  = out_pcol_r;
  assign out_row           = out_row_r;
  assign out_char          = out_char_r;
  assign out_cursor_needed = out_need_r;

  a_plain_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r != cdr_pkg::KIND_TRANSFER) |->
      !out_panel_r && (out_pcol_r == '0) && !out_row_r && (out_char_r == '0) && !out_need_r)
    else $error("non-transfer word carries cell fields");

  a_pcol_in_panel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == cdr_pkg::KIND_TRANSFER) |->
      int'(out_pcol_r) < PANEL_COLUMNS)
    else $error("panel column beyond panel width");

  a_scan_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(scan_pos_r) <= CELL_COUNT)
    else $error("scan position past end of buffer");

  a_cont_tracks_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cont_valid_r |-> cont_pos_r == scan_pos_r)
    else $error("continuity position out of step with scan");

endmodule

>>> rtl/core/char_display_dirty_refresh.sv
// Shadow buffer with changed-cell refresh for a multi-panel character display.
// Input channel (in_valid/in_ready): one command word per item - clear, set
// cursor, put at cursor, put at position, or refresh step. String writes are
// one put-at-cursor word per character.
// Result channel (out_valid/out_ready): exactly one word per command: accepted,
// rejected (out of range or unknown mode), a character transfer with panel,
// panel column, row, code and cursor_needed, or refresh pass done.
// Steps, accept to accept: clear, set cursor and rejects go from dispatch straight
// to the result step; puts add a read-modify-write of one cell through the RAM
// port; a refresh step searches groups of 8 cells with the 8-lane sent-flag scan
// until a hit, which adds a transfer step for the registered RAM read, or the
// last group, which ends the pass; it ends the pass at once when the scan
// already stands at the buffer end.
// The result sits in an output register; the next command is taken while it
// waits. If the receiver stalls with a result still held, the next command
// finishes and waits in its final step until the register frees.
// Reset (rst_n low, synchronous): cursor and scan state zero, every cell
// reads as code 0 and unsent. No clearing pass: per-cell valid bits make
// untouched cells read the fill code, so commands are taken right after reset.
module char_display_dirty_refresh #(
  parameter int NUM_PANELS    = cdr_pkg::DEF_NUM_PANELS,
  parameter int PANEL_COLUMNS = cdr_pkg::DEF_PANEL_COLUMNS,
  parameter int NUM_ROWS      = cdr_pkg::DEF_NUM_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cdr_pkg::MODE_W-1:0]      in_mode,
  input  logic [cdr_pkg::COL_IN_W-1:0]    in_column,
  input  logic [cdr_pkg::ROW_IN_W-1:0]    in_row,
  input  logic [cdr_pkg::CODE_W-1:0]      in_char_code,
  input  logic                            in_force_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cdr_pkg::KIND_W-1:0]      out_kind,
  output logic                            out_panel,
  output logic [cdr_pkg::PCOL_OUT_W-1:0]  out_panel_column,
  output logic                            out_row,
  output logic [cdr_pkg::CODE_W-1:0]      out_char,
  output logic                            out_cursor_needed
);

  // command/status between sequencer and datapath
  cdr_pkg::cdr_cmd_t  cmd;
  cdr_pkg::cdr_stat_t stat;

  // sequencer: one command word at a time, dispatch on mode,
  // search loop for refresh, then hand the result to the output register
  cdr_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: cursor, scan/continuity registers, sent and valid flags,
  // cell-code RAM, position decode and the result/output registers
  cdr_datapath #(
    .NUM_PANELS    (NUM_PANELS),
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .NUM_ROWS      (NUM_ROWS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_mode),
    .in_column         (in_column),
    .in_row            (in_row),
    .in_char_code      (in_char_code),
    .in_force_req      (in_force_req),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_panel         (out_panel),
    .out_panel_column  (out_panel_column),
    .out_row           (out_row),
    .out_char          (out_char),
    .out_cursor_needed (out_cursor_needed)
  );

endmodule
